// ===== hw/rtl/dcbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Draw-call batch merger package
// Shared call record, queue push record and default queue depth.
// ----------------------------------------------------------------------------
package dcbm_pkg;

	// Default depth of the queue between front and back (power of two, >= 2)
	localparam int unsigned QueueDepthDefault = 4;

	// One merged draw call as it leaves the block
	typedef struct packed {
		logic        [31:0] texture;
		logic        [31:0] shader;
		logic        [3:0]  blend;
		logic               clip_enable;
		logic signed [15:0] clip_x;
		logic signed [15:0] clip_y;
		logic signed [15:0] clip_w;
		logic signed [15:0] clip_h;
		logic        [31:0] first_vertex;
		logic        [31:0] num_vertices;
		logic               final_call;
	} call_t;

	// One write request from the front into the queue
	typedef struct packed {
		logic  valid;
		call_t call;
	} push_t;

endpackage

// ===== hw/rtl/dcbm_call_if.sv =====
// ----------------------------------------------------------------------------
// Draw-call input channel
// Valid/ready channel carrying one incoming draw call per request.
// ----------------------------------------------------------------------------
interface dcbm_call_if;
	logic               valid;
	logic               ready;
	logic        [31:0] texture_handle;
	logic        [31:0] shader_handle;
	logic        [3:0]  blend_select;
	logic               clip_enable;
	logic signed [15:0] clip_x;
	logic signed [15:0] clip_y;
	logic signed [15:0] clip_w;
	logic signed [15:0] clip_h;
	logic        [31:0] first_vertex;
	logic        [31:0] num_vertices;
	logic               end_of_list;

	modport source (
		output valid, texture_handle, shader_handle, blend_select, clip_enable,
		       clip_x, clip_y, clip_w, clip_h, first_vertex, num_vertices, end_of_list,
		input  ready
	);

	modport sink (
		input  valid, texture_handle, shader_handle, blend_select, clip_enable,
		       clip_x, clip_y, clip_w, clip_h, first_vertex, num_vertices, end_of_list,
		output ready
	);
endinterface

// ===== hw/rtl/dcbm_batch_if.sv =====
// ----------------------------------------------------------------------------
// Merged-batch output channel
// Valid/ready channel carrying one merged draw call per request.
// ----------------------------------------------------------------------------
interface dcbm_batch_if;
	logic               valid;
	logic               ready;
	logic        [31:0] out_texture;
	logic        [31:0] out_program;
	logic        [3:0]  out_blend;
	logic               out_clip_enable;
	logic signed [15:0] out_clip_x;
	logic signed [15:0] out_clip_y;
	logic signed [15:0] out_clip_w;
	logic signed [15:0] out_clip_h;
	logic        [31:0] out_first_vertex;
	logic        [31:0] out_num_vertices;
	logic               final_call;

	modport source (
		output valid, out_texture, out_program, out_blend, out_clip_enable,
		       out_clip_x, out_clip_y, out_clip_w, out_clip_h,
		       out_first_vertex, out_num_vertices, final_call,
		input  ready
	);

	modport sink (
		input  valid, out_texture, out_program, out_blend, out_clip_enable,
		       out_clip_x, out_clip_y, out_clip_w, out_clip_h,
		       out_first_vertex, out_num_vertices, final_call,
		output ready
	);
endinterface

// ===== hw/rtl/dcbm_front.sv =====
// ----------------------------------------------------------------------------
// Draw-call batch merger front end
// Holds the pending call, classifies each incoming call as fold or break,
// and issues up to two queue writes per accepted call.
// ----------------------------------------------------------------------------
module dcbm_front (
	input  logic            clk,
	input  logic            arst_n,
	dcbm_call_if.sink       calls,
	input  logic            room,
	output dcbm_pkg::push_t push_a,
	output dcbm_pkg::push_t push_b,
	output logic            pend_valid
);

	logic            pend_valid_q;
	dcbm_pkg::call_t pend_q;
	logic [31:0]     pend_end_q;

	logic            accept;
	logic            same_state;
	logic            merge;
	logic [31:0]     sum_count;
	dcbm_pkg::call_t incoming;
	dcbm_pkg::call_t merged;

	assign calls.ready = room;
	assign accept      = calls.valid & room;
	assign pend_valid  = pend_valid_q;

	// Classify: fold when state matches and the vertex range continues
	always_comb begin
		same_state = (pend_q.texture == calls.texture_handle) &&
		             (pend_q.shader == calls.shader_handle) &&
		             (pend_q.blend == calls.blend_select) &&
		             (pend_q.clip_enable == calls.clip_enable) &&
		             (!pend_q.clip_enable ||
		              ((pend_q.clip_x == calls.clip_x) && (pend_q.clip_y == calls.clip_y) &&
		               (pend_q.clip_w == calls.clip_w) && (pend_q.clip_h == calls.clip_h))) &&
		             (pend_end_q == calls.first_vertex);
		merge      = pend_valid_q & same_state;
		sum_count  = pend_q.num_vertices + calls.num_vertices;
	end

	// Build the incoming and the folded records
	always_comb begin
		incoming.texture      = calls.texture_handle;
		incoming.shader       = calls.shader_handle;
		incoming.blend        = calls.blend_select;
		incoming.clip_enable  = calls.clip_enable;
		incoming.clip_x       = calls.clip_x;
		incoming.clip_y       = calls.clip_y;
		incoming.clip_w       = calls.clip_w;
		incoming.clip_h       = calls.clip_h;
		incoming.first_vertex = calls.first_vertex;
		incoming.num_vertices = calls.num_vertices;
		incoming.final_call   = 1'b0;

		merged              = pend_q;
		merged.num_vertices = sum_count;
	end

	// Issue writes: the broken-off pending call first, then the flush
	always_comb begin
		push_a.valid           = accept & pend_valid_q & ~merge;
		push_a.call            = pend_q;
		push_a.call.final_call = 1'b0;

		push_b.valid           = accept & calls.end_of_list;
		push_b.call            = merge ? merged : incoming;
		push_b.call.final_call = 1'b1;
	end

	// Hold or drop the pending call
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= ~calls.end_of_list;
		end
	end

	// Fold into or replace the pending payload; track its end vertex
	always_ff @(posedge clk) begin
		if (accept) begin
			if (merge) begin
				pend_q.num_vertices <= sum_count;
				pend_end_q          <= pend_end_q + calls.num_vertices;
			end else begin
				pend_q     <= incoming;
				pend_end_q <= calls.first_vertex + calls.num_vertices;
			end
		end
	end

endmodule

// ===== hw/rtl/dcbm_queue.sv =====
// ----------------------------------------------------------------------------
// Draw-call batch merger queue
// Small register queue, two writes and one read per cycle, between the
// front end and the output stage.
// ----------------------------------------------------------------------------
module dcbm_queue #(
	parameter int unsigned Depth = dcbm_pkg::QueueDepthDefault,
	parameter int unsigned CntW  = $clog2(Depth + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dcbm_pkg::push_t push_a,
	input  dcbm_pkg::push_t push_b,
	input  logic            pop,
	output dcbm_pkg::call_t head,
	output logic            head_valid,
	output logic            room,
	output logic [CntW-1:0] level
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	dcbm_pkg::call_t mem [Depth];
	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] tail_q;
	logic [CntW-1:0] level_q;
	logic [PtrW-1:0] wr_b_idx;

	// Second write lands after the first, or at the tail when alone
	assign wr_b_idx   = tail_q + PtrW'(push_a.valid);
	assign head       = mem[head_q];
	assign head_valid = (level_q != '0);
	assign room       = (level_q <= CntW'(Depth - 2));
	assign level      = level_q;

	// Store written entries
	always_ff @(posedge clk) begin
		if (push_a.valid) begin
			mem[tail_q] <= push_a.call;
		end
		if (push_b.valid) begin
			mem[wr_b_idx] <= push_b.call;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			tail_q  <= tail_q + PtrW'(push_a.valid) + PtrW'(push_b.valid);
			head_q  <= head_q + PtrW'(pop);
			level_q <= level_q + CntW'(push_a.valid) + CntW'(push_b.valid) - CntW'(pop);
		end
	end

endmodule

// ===== hw/rtl/dcbm_back.sv =====
// ----------------------------------------------------------------------------
// Draw-call batch merger output stage
// Output register that drains the queue onto the batch channel.
// ----------------------------------------------------------------------------
module dcbm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dcbm_pkg::call_t head,
	input  logic            head_valid,
	output logic            pop,
	dcbm_batch_if.source    batches
);

	logic            out_valid_q;
	dcbm_pkg::call_t out_q;
	logic            load;

	// Take the queue head when the register is empty or being drained
	assign load = head_valid & (~out_valid_q | batches.ready);
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (batches.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head;
		end
	end

	// Drive the channel from the register
	assign batches.valid            = out_valid_q;
	assign batches.out_texture      = out_q.texture;
	assign batches.out_program      = out_q.shader;
	assign batches.out_blend        = out_q.blend;
	assign batches.out_clip_enable  = out_q.clip_enable;
	assign batches.out_clip_x       = out_q.clip_x;
	assign batches.out_clip_y       = out_q.clip_y;
	assign batches.out_clip_w       = out_q.clip_w;
	assign batches.out_clip_h       = out_q.clip_h;
	assign batches.out_first_vertex = out_q.first_vertex;
	assign batches.out_num_vertices = out_q.num_vertices;
	assign batches.final_call       = out_q.final_call;

endmodule

// ===== hw/rtl/draw_call_batch_merger.sv =====
// ----------------------------------------------------------------------------
// Draw-call batch merger
// Folds consecutive draw calls that share texture, shader, blend mode and
// scissor state and whose vertex ranges join up into one larger call.
//
// Channels: calls (sink) carries incoming draw calls; batches (source)
// carries merged calls. Both are valid/ready; a request moves on a rising
// edge with valid and ready high.
// Throughput: one call per cycle while batches is not stalled. A call that
// breaks a batch and also ends the list produces two results, which drain
// one after the other. A result is written to the queue when the call that
// closes it is taken (the next non-matching call, or a call with
// end_of_list), then passes through the output register onto batches; the
// second of a pair follows the first.
// calls.ready is high while the queue between front end and output register
// has room for two entries, so a stalled receiver fills the queue and then
// holds off calls; no result is lost.
// Reset: nothing is pending and the queue and output register are empty.
// QueueDepth must be a power of two and at least 2.
// ----------------------------------------------------------------------------
module draw_call_batch_merger #(
	parameter int unsigned QueueDepth = dcbm_pkg::QueueDepthDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	dcbm_call_if.sink    calls,
	dcbm_batch_if.source batches
);

	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	dcbm_pkg::push_t push_a;
	dcbm_pkg::push_t push_b;
	dcbm_pkg::call_t head;
	logic            head_valid;
	logic            pop;
	logic            room;
	logic            pend_valid;
	logic [CntW-1:0] level;

	dcbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.calls      (calls),
		.room       (room),
		.push_a     (push_a),
		.push_b     (push_b),
		.pend_valid (pend_valid)
	);

	dcbm_queue #(
		.Depth (QueueDepth),
		.CntW  (CntW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_a     (push_a),
		.push_b     (push_b),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.room       (room),
		.level      (level)
	);

	dcbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.batches    (batches)
	);

	// Queue never holds more than its depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= CntW'(QueueDepth))
		else $error("queue level exceeds depth");

	// A call is only taken with space for two results
	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(calls.valid && calls.ready) |-> (level <= CntW'(QueueDepth - 2)))
		else $error("call accepted without room for two results");

	// End of list leaves nothing pending
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(calls.valid && calls.ready && calls.end_of_list) |=> !pend_valid)
		else $error("pending call survives end of list");

	// A first call of a batch that does not end the list writes nothing
	a_first_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(calls.valid && calls.ready && !pend_valid && !calls.end_of_list)
		|=> (level <= $past(level)))
		else $error("result written for a freshly held call");

endmodule

// ===== tb/tb_draw_call_batch_merger.sv =====
// ----------------------------------------------------------------------------
// Draw-call batch merger testbench
// Sends draw calls through the calls channel and checks every merged call on
// the batches channel against a predictor of the folding rules. The run starts
// with a directed list, then runs random phases with sender idling, receiver
// stalls, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_draw_call_batch_merger;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkPeriod    = 8;
	localparam int RunLimitNs   = 3_000_000;
	localparam int DrainLimit   = 2000;
	localparam int PhaseCalls   = 225;
	localparam int NumPhases    = 4;

	// One incoming draw call as driven on the calls channel
	typedef struct packed {
		logic        [31:0] texture;
		logic        [31:0] shader;
		logic        [3:0]  blend;
		logic               clip_enable;
		logic signed [15:0] clip_x;
		logic signed [15:0] clip_y;
		logic signed [15:0] clip_w;
		logic signed [15:0] clip_h;
		logic        [31:0] first_vertex;
		logic        [31:0] num_vertices;
		logic               end_of_list;
	} draw_call_t;

	// Predicts merged calls from accepted requests and checks the results
	class batch_scoreboard;
		bit              held_valid;
		dcbm_pkg::call_t held;
		dcbm_pkg::call_t merged_q[$];
		int              mismatches;
		int              calls_noted;
		int              calls_folded;
		int              batches_checked;
		int              lists_closed;

		function new();
			held_valid = 1'b0;
			held       = '0;
		endfunction

		function int outstanding();
			return merged_q.size();
		endfunction

		// Fold the call into the held batch, or close the batch and hold the call
		function void note_call(draw_call_t c);
			logic [31:0]     range_end;
			bit              fold;
			dcbm_pkg::call_t closed;
			calls_noted++;
			range_end = held.first_vertex + held.num_vertices;
			fold = held_valid && held.texture == c.texture && held.shader == c.shader &&
				held.blend == c.blend && held.clip_enable == c.clip_enable &&
				(!held.clip_enable ||
				 {held.clip_x, held.clip_y, held.clip_w, held.clip_h} ==
				 {c.clip_x, c.clip_y, c.clip_w, c.clip_h}) &&
				range_end == c.first_vertex;
			if (fold) begin
				held.num_vertices = held.num_vertices + c.num_vertices;
				calls_folded++;
			end else begin
				if (held_valid) begin
					closed = held;
					closed.final_call = 1'b0;
					merged_q.push_back(closed);
				end
				held_valid        = 1'b1;
				held.texture      = c.texture;
				held.shader       = c.shader;
				held.blend        = c.blend;
				held.clip_enable  = c.clip_enable;
				held.clip_x       = c.clip_x;
				held.clip_y       = c.clip_y;
				held.clip_w       = c.clip_w;
				held.clip_h       = c.clip_h;
				held.first_vertex = c.first_vertex;
				held.num_vertices = c.num_vertices;
				held.final_call   = 1'b0;
			end
			// Flush on the last call of a list
			if (c.end_of_list) begin
				closed = held;
				closed.final_call = 1'b1;
				merged_q.push_back(closed);
				held_valid = 1'b0;
			end
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				if (mismatches < 10)
					$display("  result %0d field %s: expected %h, got %h",
						batches_checked, name, want, seen);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		// Compare one merged call with the oldest prediction
		function void check_batch(dcbm_pkg::call_t got);
			dcbm_pkg::call_t want;
			bit              ok;
			batches_checked++;
			if (merged_q.size() == 0) begin
				if (mismatches < 10)
					$display("Mismatch: unexpected merged call %0d, texture %h first %h",
						batches_checked, got.texture, got.first_vertex);
				mismatches++;
				return;
			end
			want = merged_q.pop_front();
			if (want.final_call)
				lists_closed++;
			if (mismatches < 10 && want !== got)
				$display("Mismatch at %0t ns:", $time);
			ok = 1'b1;
			ok &= field_ok("texture", want.texture, got.texture);
			ok &= field_ok("shader", want.shader, got.shader);
			ok &= field_ok("blend", 32'(want.blend), 32'(got.blend));
			ok &= field_ok("clip_enable", 32'(want.clip_enable), 32'(got.clip_enable));
			ok &= field_ok("clip_x", 32'(want.clip_x), 32'(got.clip_x));
			ok &= field_ok("clip_y", 32'(want.clip_y), 32'(got.clip_y));
			ok &= field_ok("clip_w", 32'(want.clip_w), 32'(got.clip_w));
			ok &= field_ok("clip_h", 32'(want.clip_h), 32'(got.clip_h));
			ok &= field_ok("first_vertex", want.first_vertex, got.first_vertex);
			ok &= field_ok("num_vertices", want.num_vertices, got.num_vertices);
			ok &= field_ok("final_call", 32'(want.final_call), 32'(got.final_call));
			if (!ok)
				mismatches++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dcbm_call_if  calls_if();
	dcbm_batch_if batches_if();

	draw_call_batch_merger dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.calls   (calls_if),
		.batches (batches_if)
	);

	batch_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_len    = 0;
	int calls_sent     = 0;

	always #(ClkPeriod / 2) clk = ~clk;

	// Hold every input at a known value from time zero
	initial begin
		arst_n                  = 1'b0;
		calls_if.valid          = 1'b0;
		calls_if.texture_handle = '0;
		calls_if.shader_handle  = '0;
		calls_if.blend_select   = '0;
		calls_if.clip_enable    = 1'b0;
		calls_if.clip_x         = '0;
		calls_if.clip_y         = '0;
		calls_if.clip_w         = '0;
		calls_if.clip_h         = '0;
		calls_if.first_vertex   = '0;
		calls_if.num_vertices   = '0;
		calls_if.end_of_list    = 1'b0;
		batches_if.ready        = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holdoff_len > 0) begin
				batches_if.ready <= 1'b0;
				repeat (holdoff_len - 1) @(negedge clk);
				holdoff_len = 0;
			end else begin
				batches_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check every merged call that moves on the batches channel
	always @(posedge clk) begin
		dcbm_pkg::call_t got;
		if (batches_if.valid === 1'b1 && batches_if.ready === 1'b1) begin
			got.texture      = batches_if.out_texture;
			got.shader       = batches_if.out_program;
			got.blend        = batches_if.out_blend;
			got.clip_enable  = batches_if.out_clip_enable;
			got.clip_x       = batches_if.out_clip_x;
			got.clip_y       = batches_if.out_clip_y;
			got.clip_w       = batches_if.out_clip_w;
			got.clip_h       = batches_if.out_clip_h;
			got.first_vertex = batches_if.out_first_vertex;
			got.num_vertices = batches_if.out_num_vertices;
			got.final_call   = batches_if.final_call;
			sb.check_batch(got);
		end
	end

	// Give up on a hung run
	initial begin
		#(RunLimitNs);
		$display("TB_ERROR");
		$finish;
	end

	function automatic draw_call_t make_call(logic [31:0] tex, logic [31:0] shd,
			logic [3:0] bl, logic en, logic [15:0] x, logic [15:0] y, logic [15:0] w,
			logic [15:0] h, logic [31:0] first, logic [31:0] num, logic eol);
		draw_call_t c;
		c.texture      = tex;
		c.shader       = shd;
		c.blend        = bl;
		c.clip_enable  = en;
		c.clip_x       = x;
		c.clip_y       = y;
		c.clip_w       = w;
		c.clip_h       = h;
		c.first_vertex = first;
		c.num_vertices = num;
		c.end_of_list  = eol;
		return c;
	endfunction

	// Mostly short counts, with zero and wrapping counts now and then
	function automatic logic [31:0] random_count();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF - 32'($urandom_range(15));
			default: return 32'($urandom_range(300, 1));
		endcase
	endfunction

	function automatic logic [31:0] random_handle();
		return $urandom_range(1) ? $urandom : 32'($urandom_range(3));
	endfunction

	// Continue the running batch, break it on one field, or start afresh
	function automatic draw_call_t next_call(draw_call_t prev);
		draw_call_t c;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			c = prev;
			c.first_vertex = prev.first_vertex + prev.num_vertices;
			c.num_vertices = random_count();
			if (!c.clip_enable && $urandom_range(1)) begin
				c.clip_x = 16'($urandom);
				c.clip_y = 16'($urandom);
				c.clip_w = 16'($urandom);
				c.clip_h = 16'($urandom);
			end
			if (pick >= 60) begin
				case ($urandom_range(5))
					0: c.texture ^= 32'd1 << $urandom_range(31);
					1: c.shader ^= 32'd1 << $urandom_range(31);
					2: c.blend ^= 4'($urandom_range(15, 1));
					3: c.clip_enable = ~c.clip_enable;
					4: begin
						c.clip_enable = 1'b1;
						c.clip_y ^= 16'd1 << $urandom_range(15);
					end
					default: c.first_vertex += $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
				endcase
			end
		end else begin
			c.texture      = random_handle();
			c.shader       = random_handle();
			c.blend        = 4'($urandom_range(15));
			c.clip_enable  = 1'($urandom_range(1));
			c.clip_x       = 16'($urandom);
			c.clip_y       = 16'($urandom);
			c.clip_w       = 16'($urandom);
			c.clip_h       = 16'($urandom);
			c.first_vertex = ($urandom_range(3) == 0) ?
				32'hFFFF_FF00 + 32'($urandom_range(255)) : $urandom;
			c.num_vertices = random_count();
		end
		c.end_of_list = ($urandom_range(99) < 8);
		return c;
	endfunction

	function automatic int pick_gap();
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < send_idle_pct)
			gap++;
		return gap;
	endfunction

	// Offer one call and hold it until the block takes it
	task automatic send_call(input draw_call_t c);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			calls_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		calls_if.texture_handle <= c.texture;
		calls_if.shader_handle  <= c.shader;
		calls_if.blend_select   <= c.blend;
		calls_if.clip_enable    <= c.clip_enable;
		calls_if.clip_x         <= c.clip_x;
		calls_if.clip_y         <= c.clip_y;
		calls_if.clip_w         <= c.clip_w;
		calls_if.clip_h         <= c.clip_h;
		calls_if.first_vertex   <= c.first_vertex;
		calls_if.num_vertices   <= c.num_vertices;
		calls_if.end_of_list    <= c.end_of_list;
		calls_if.valid          <= 1'b1;
		do @(posedge clk); while (calls_if.ready !== 1'b1);
		sb.note_call(c);
		calls_sent++;
	endtask

	// Stop offering and wait for every predicted merged call to arrive
	task automatic wait_drained();
		int waited;
		waited = 0;
		@(negedge clk);
		calls_if.valid <= 1'b0;
		while (sb.outstanding() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		if (sb.outstanding() != 0) begin
			$display("Mismatch: %0d merged calls never arrived", sb.outstanding());
			sb.mismatches++;
		end
	endtask

	task automatic run_directed();
		draw_call_t c;
		// Lone call ending a list, all fields zero
		c = make_call('0, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b1);
		send_call(c);
		// All-ones handles, extreme rectangle, vertex range wrapping past zero
		c = make_call(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000, 32'hFFFF_FFF0, 32'h10, 1'b0);
		send_call(c);
		c.first_vertex = 32'd0;
		c.num_vertices = 32'hFFFF_FFFF;
		send_call(c);
		c.first_vertex = 32'hFFFF_FFFF;
		c.num_vertices = 32'd1;
		c.end_of_list  = 1'b1;
		send_call(c);
		// Scissor off: differing rectangles still fold, first rectangle kept
		c = make_call(32'd1, 32'd2, 4'd3, 1'b0, 16'd1, 16'd2, 16'd3, 16'd4,
			32'd100, 32'd10, 1'b0);
		send_call(c);
		c.clip_x = 16'd5;
		c.clip_y = 16'd6;
		c.clip_w = 16'd7;
		c.clip_h = 16'd8;
		c.first_vertex += c.num_vertices;
		c.num_vertices = 32'd5;
		send_call(c);
		// Break the batch on each compared field in turn
		c.first_vertex += c.num_vertices;
		c.texture = 32'd5;
		send_call(c);
		c.first_vertex += c.num_vertices;
		c.shader = 32'd3;
		send_call(c);
		c.first_vertex += c.num_vertices;
		c.blend = 4'd4;
		send_call(c);
		c.first_vertex += c.num_vertices;
		c.clip_enable = 1'b1;
		send_call(c);
		c.first_vertex += c.num_vertices;
		c.clip_w = 16'hFFFF;
		send_call(c);
		// Scissor on with equal rectangles folds
		c.first_vertex += c.num_vertices;
		c.num_vertices = 32'd7;
		send_call(c);
		// Vertex range one past the end breaks
		c.first_vertex += c.num_vertices + 32'd1;
		send_call(c);
		c.first_vertex += c.num_vertices;
		c.num_vertices = 32'd0;
		c.end_of_list  = 1'b1;
		send_call(c);
		// Zero counts fold; a break that also ends the list closes two batches
		c = make_call(32'd9, 32'd9, 4'd9, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			32'd0, 32'd0, 1'b0);
		send_call(c);
		send_call(c);
		c.texture     = 32'd10;
		c.end_of_list = 1'b1;
		send_call(c);
		wait_drained();
	endtask

	// Main sequence: reset, directed list, random phases, drain and verdict
	initial begin
		draw_call_t c;
		int         idle_send[NumPhases];
		int         idle_recv[NumPhases];
		idle_send = '{0, 46, 0, 27};
		idle_recv = '{0, 0, 46, 27};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		c = make_call(32'd1, 32'd1, 4'd0, 1'b0, '0, '0, '0, '0, '0, 32'd4, 1'b0);
		for (int p = 0; p < NumPhases; p++) begin
			send_idle_pct  = idle_send[p];
			recv_stall_pct = idle_recv[p];
			for (int i = 0; i < PhaseCalls; i++) begin
				c = next_call(c);
				if (p == NumPhases - 1 && i == PhaseCalls - 1)
					c.end_of_list = 1'b1;
				// Long output hold-off while calls keep coming
				if ((p == 0 && i == 30) || (p == 3 && i == 100))
					holdoff_len = 90;
				send_call(c);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$display("Mismatch: %0d merged calls left over", sb.outstanding());
			sb.mismatches++;
		end

		$display("Sent %0d draw calls, %0d folded into a running batch;",
			calls_sent, sb.calls_folded);
		$display("checked %0d merged calls, %0d closing a list; %0d mismatches.",
			sb.batches_checked, sb.lists_closed, sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
